// ----- rtl/mfw_pkg.sv -----
// mfw_pkg: shared constants, register indexes and types of the median filter window unit
// no dependencies; used by the interfaces, the submodules, the top level and the checker

package mfw_pkg;

    // defaults for the top level parameters
    localparam int WINDOW_DEF    = 3;
    localparam int MAX_WIDTH_DEF = 1024;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int IW_W       = 11;
    localparam int IH_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // register reset values
    localparam logic [IW_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [IH_W-1:0] HEIGHT_RESET = 12'd480;

    // load enables of the two median stages
    typedef struct packed {
        logic ld_cmp;
        logic ld_rank;
    } t_med_ctl;

endpackage

// ----- rtl/mfw_if.sv -----
// mfw_if: valid/ready channel interfaces for pixel input, result output and register writes
// depends on mfw_pkg for field widths

interface mfw_pix_if;
    logic                       valid;
    logic                       ready;
    logic [mfw_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface mfw_res_if;
    logic                       valid;
    logic                       ready;
    logic [mfw_pkg::PIX_W-1:0]  median_value;
    logic [mfw_pkg::ROW_W-1:0]  centre_row;
    logic [mfw_pkg::COL_W-1:0]  centre_col;
    logic                       frame_done;

    modport source (output valid, output median_value, output centre_row,
                    output centre_col, output frame_done, input ready);
    modport sink   (input valid, input median_value, input centre_row,
                    input centre_col, input frame_done, output ready);
endinterface

interface mfw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mfw_pkg::CFG_IDX_W-1:0]   idx;
    logic [mfw_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// ----- rtl/mfw_line_mem.sv -----
// mfw_line_mem: line store memory, one word per column holding all buffered rows
// one write and one registered read per cycle, write data forwarded on a same-address read

module mfw_line_mem #(
    parameter int DEPTH = mfw_pkg::MAX_WIDTH_DEF,
    parameter int DW    = (mfw_pkg::WINDOW_DEF - 1) * mfw_pkg::PIX_W
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            // same column written in this cycle: take the new word
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/mfw_median.sv -----
// mfw_median: two-stage rank selection median over a square window of pixels
// depends on mfw_pkg for pixel width and the stage control struct

module mfw_median #(
    parameter int N = mfw_pkg::WINDOW_DEF * mfw_pkg::WINDOW_DEF
) (
    input  logic                                 i_clk,
    input  mfw_pkg::t_med_ctl                    i_ctl,
    input  logic [N-1:0][mfw_pkg::PIX_W-1:0]     i_win,
    output logic [mfw_pkg::PIX_W-1:0]            o_median
);

    localparam int              RW  = $clog2(N);
    localparam logic [RW-1:0]   MID = RW'(N / 2);

    logic [N-1:0][mfw_pkg::PIX_W-1:0] r_val_c;
    logic [N-1:0][mfw_pkg::PIX_W-1:0] r_val_r;
    logic [N-1:0][N-1:0]              r_below;
    logic [N-1:0][N-1:0]              n_below;
    logic [N-1:0][RW-1:0]             r_rank;

    // element j sorts below element i; ties broken by position
    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                n_below[i][j] = (i_win[j] < i_win[i]) ||
                                ((j < i) && (i_win[j] == i_win[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_cmp) begin
            r_val_c <= i_win;
            r_below <= n_below;
        end
        if (i_ctl.ld_rank) begin
            r_val_r <= r_val_c;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= RW'($countones(r_below[i]));
            end
        end
    end

    // ranks form a permutation, so exactly one element matches
    always_comb begin
        o_median = '0;
        for (int i = 0; i < N; i++) begin
            if (r_rank[i] == MID) begin
                o_median = o_median | r_val_r[i];
            end
        end
    end

endmodule

// ----- rtl/median_filter_window_unit.sv -----
// median_filter_window_unit: streaming WINDOW x WINDOW median filter, one pixel per cycle unless stalled
// a result passes the line store read, compare, rank and output registers; a stalled output holds it
// throughput: one pixel per cycle unless stalled, set by the line store's one read and one write per cycle
// reset (synchronous, active low): counters, window and valids clear, width 640, height 480
// the line store has no reset and no clearing pass; border positions give no result

module median_filter_window_unit #(
    parameter int WINDOW    = mfw_pkg::WINDOW_DEF,
    parameter int MAX_WIDTH = mfw_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfw_pix_if.sink     i_pix,
    mfw_res_if.source   o_res,
    mfw_cfg_if.sink     i_cfg
);

    localparam int PW    = mfw_pkg::PIX_W;
    localparam int RWD   = mfw_pkg::ROW_W;
    localparam int OCW   = mfw_pkg::COL_W;
    localparam int N     = WINDOW * WINDOW;
    localparam int LINES = WINDOW - 1;
    localparam int HALF  = WINDOW / 2;
    localparam int LW    = LINES * PW;
    // column counter width and a compare width that also holds the width register
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int XW    = (CW + 1 > mfw_pkg::IW_W) ? CW + 1 : mfw_pkg::IW_W;

    // ---------------------------------------------------------------
    // configuration registers, always ready
    // ---------------------------------------------------------------
    logic [mfw_pkg::IW_W-1:0] r_image_width;
    logic [mfw_pkg::IH_W-1:0] r_image_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= mfw_pkg::WIDTH_RESET;
            r_image_height <= mfw_pkg::HEIGHT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.idx)
                mfw_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg.data[mfw_pkg::IW_W-1:0];
                end
                mfw_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg.data[mfw_pkg::IH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // effective geometry: zero reads as one, width saturates at the line store depth
    logic [XW-1:0]  w_eff;
    logic [RWD-1:0] h_eff;

    always_comb begin
        w_eff = XW'(r_image_width);
        if (w_eff == '0) begin
            w_eff = XW'(1);
        end else if (w_eff > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end
        h_eff = (r_image_height == '0) ? RWD'(1) : r_image_height;
    end

    // ---------------------------------------------------------------
    // pipeline handshake: each stage loads when empty or when it drains
    // ---------------------------------------------------------------
    logic r_s1_valid;
    logic r_m1_valid;
    logic r_m2_valid;
    logic r_out_valid;
    logic r_s1_emit;

    logic en_out;
    logic en_m2;
    logic en_m1;
    logic s1_move;
    logic in_ready;
    logic accept;

    assign en_out   = !r_out_valid || o_res.ready;
    assign en_m2    = !r_m2_valid || en_out;
    assign en_m1    = !r_m1_valid || en_m2;
    // a border word needs no slot in the median stages
    assign s1_move  = r_s1_valid && (!r_s1_emit || en_m1);
    assign in_ready = !r_s1_valid || s1_move;
    assign accept   = i_pix.valid && in_ready;

    assign i_pix.ready = in_ready;

    // ---------------------------------------------------------------
    // raster position of the next word
    // ---------------------------------------------------------------
    logic [CW-1:0]  r_col;
    logic [RWD-1:0] r_row;
    logic           col_last;
    logic           row_last;
    logic           emit;

    assign col_last = (XW'(r_col) + XW'(1)) >= w_eff;
    assign row_last = ((RWD + 1)'(r_row) + (RWD + 1)'(1)) >= (RWD + 1)'(h_eff);
    assign emit     = (r_row >= RWD'(WINDOW - 1)) && (r_col >= CW'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + RWD'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: line store read in flight, word and its coordinates held
    // ---------------------------------------------------------------
    logic [PW-1:0]  r_s1_pixel;
    logic [CW-1:0]  r_s1_col;
    logic           r_s1_last;
    logic [RWD-1:0] r_s1_crow;
    logic [OCW-1:0] r_s1_ccol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= accept;
            r_s1_emit  <= accept && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pix.pixel;
            r_s1_col   <= r_col;
            r_s1_last  <= row_last && col_last;
            r_s1_crow  <= r_row - RWD'(HALF);
            r_s1_ccol  <= OCW'(r_col - CW'(HALF));
        end
    end

    // line store: one word per column, oldest row in the low slot
    logic [LW-1:0] rd_word;
    logic [LW-1:0] wr_word;

    mfw_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (LW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_word),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (rd_word)
    );

    // age the rows of this column and push the new word on top
    always_comb begin
        wr_word = '0;
        for (int k = 0; k < LINES - 1; k++) begin
            wr_word[k*PW +: PW] = rd_word[(k+1)*PW +: PW];
        end
        wr_word[(LINES-1)*PW +: PW] = r_s1_pixel;
    end

    // ---------------------------------------------------------------
    // sliding window: shift left, new column enters on the right
    // ---------------------------------------------------------------
    logic [N-1:0][PW-1:0]      r_window;
    logic [N-1:0][PW-1:0]      n_window;
    logic [WINDOW-1:0][PW-1:0] column;

    always_comb begin
        for (int k = 0; k < LINES; k++) begin
            column[k] = rd_word[k*PW +: PW];
        end
        column[WINDOW-1] = r_s1_pixel;
        for (int k = 0; k < WINDOW; k++) begin
            for (int m = 0; m < WINDOW - 1; m++) begin
                n_window[k*WINDOW + m] = r_window[k*WINDOW + m + 1];
            end
            n_window[k*WINDOW + WINDOW - 1] = column[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (s1_move) begin
            r_window <= n_window;
        end
    end

    // ---------------------------------------------------------------
    // median stages: compare matrix, then ranks, then selection
    // ---------------------------------------------------------------
    mfw_pkg::t_med_ctl med_ctl;
    logic [PW-1:0]     median;

    assign med_ctl.ld_cmp  = en_m1;
    assign med_ctl.ld_rank = en_m2;

    mfw_median #(
        .N (N)
    ) u_median (
        .i_clk    (i_clk),
        .i_ctl    (med_ctl),
        .i_win    (n_window),
        .o_median (median)
    );

    logic [RWD-1:0] r_m1_crow;
    logic [OCW-1:0] r_m1_ccol;
    logic           r_m1_last;
    logic [RWD-1:0] r_m2_crow;
    logic [OCW-1:0] r_m2_ccol;
    logic           r_m2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid  <= 1'b0;
            r_m2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_m1) begin
                r_m1_valid <= s1_move && r_s1_emit;
            end
            if (en_m2) begin
                r_m2_valid <= r_m1_valid;
            end
            if (en_out) begin
                r_out_valid <= r_m2_valid;
            end
        end
    end

    // coordinates travel beside the median stages
    logic [PW-1:0]  r_out_median;
    logic [RWD-1:0] r_out_crow;
    logic [OCW-1:0] r_out_ccol;
    logic           r_out_last;

    always_ff @(posedge i_clk) begin
        if (en_m1) begin
            r_m1_crow <= r_s1_crow;
            r_m1_ccol <= r_s1_ccol;
            r_m1_last <= r_s1_last;
        end
        if (en_m2) begin
            r_m2_crow <= r_m1_crow;
            r_m2_ccol <= r_m1_ccol;
            r_m2_last <= r_m1_last;
        end
        if (en_out) begin
            r_out_median <= median;
            r_out_crow   <= r_m2_crow;
            r_out_ccol   <= r_m2_ccol;
            r_out_last   <= r_m2_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.median_value = r_out_median;
    assign o_res.centre_row   = r_out_crow;
    assign o_res.centre_col   = r_out_ccol;
    assign o_res.frame_done   = r_out_last;

endmodule

// ----- rtl/mfw_checker.sv -----
// mfw_checker: port-level assertions on the result channel of the median filter window unit
// depends on mfw_pkg; bound to median_filter_window_unit at the end of this file

module mfw_checker #(
    parameter int WINDOW = mfw_pkg::WINDOW_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [mfw_pkg::PIX_W-1:0]  i_median_value,
    input logic [mfw_pkg::ROW_W-1:0]  i_centre_row,
    input logic [mfw_pkg::COL_W-1:0]  i_centre_col,
    input logic                       i_frame_done
);

    localparam logic [mfw_pkg::ROW_W-1:0] HALF_ROW = mfw_pkg::ROW_W'(WINDOW / 2);

    // nothing left over from before reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_res_valid)
        else $error("result valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_median_value) && $stable(i_centre_row) &&
            $stable(i_centre_col) && $stable(i_frame_done))
        else $error("result changed while stalled");

    // top border rows never give a result
    a_interior_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_centre_row >= HALF_ROW)
        else $error("result reported on a border row");

endmodule

bind median_filter_window_unit mfw_checker #(
    .WINDOW (WINDOW)
) u_mfw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_median_value (o_res.median_value),
    .i_centre_row   (o_res.centre_row),
    .i_centre_col   (o_res.centre_col),
    .i_frame_done   (o_res.frame_done)
);
